// ===== hw/rtl/ast_pkg.sv =====
// Shared constants, request/status codes and the cell control bus for the set store.
package ast_pkg;

  // Store geometry
  localparam int CAPACITY = 64;
  localparam int ELEM_W   = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the ports
  localparam int REQ_W     = 2;
  localparam int VAL_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic              cmp;        // compare phase
    logic              exec;       // update phase
    logic [REQ_W-1:0]  req;
    logic [ELEM_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic              full;
    logic              any_match;  // some held entry matched
  } cell_bus_t;

endpackage

// ===== hw/rtl/array_set_table_top.sv =====
// Top level of the unsorted bounded set store: sequencer plus the chain of entry cells.
//
// Usage:
//   Input channel: drive in_req_type (0 add, 1 remove, 2 query) and in_elem_value
//   with start high; the transaction is taken at a rising edge where busy is low.
//   Result channel: out_valid is high for exactly one cycle with out_status,
//   out_found and out_entry_count; the receiver must take it then, it cannot stall.
// Sequence: an accepted transaction passes the compare state and the update state,
//   and the result strobe is registered at the end of the update state. In the
//   compare state every cell compares its entry; in the update state the last match
//   is resolved through the neighbor ripple and all cells shift or append at once.
//   busy stays high until then, so no new transaction is taken while one is in work;
//   busy drops in the cycle the result is shown, so the next transaction can be
//   taken at the same edge that ends the result cycle.
// Reset (rst_n low, synchronous): count goes to zero, the sequencer idles and no
//   result is shown. Entry contents are not cleared; only entries below the count
//   are ever compared.
// Adds beyond the capacity report full and are dropped; a remove with no match
//   reports not present and changes nothing.
module array_set_table_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [ast_pkg::REQ_W-1:0]          in_req_type,
  input  logic [ast_pkg::VAL_W-1:0]          in_elem_value,
  output logic                               out_valid,
  output logic [ast_pkg::STATUS_W-1:0]       out_status,
  output logic                               out_found,
  output logic [ast_pkg::OUT_CNT_W-1:0]      out_entry_count
);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_EXEC} state_t;

  state_t                          state_r;
  logic [ast_pkg::REQ_W-1:0]       req_r;
  logic [ast_pkg::ELEM_W-1:0]      value_r;
  logic [ast_pkg::CNT_W-1:0]       count_r;
  logic [ast_pkg::CNT_W-1:0]       count_nxt;
  logic                            out_valid_r;
  logic [ast_pkg::STATUS_W-1:0]    out_status_r;
  logic [ast_pkg::STATUS_W-1:0]    status_nxt;
  logic                            out_found_r;
  logic                            found_nxt;
  logic [ast_pkg::OUT_CNT_W-1:0]   out_count_r;
  logic                            accept;
  logic                            full;
  ast_pkg::cell_bus_t              bus;

  logic [ast_pkg::ELEM_W-1:0]      entry_q [ast_pkg::CAPACITY];
  logic [ast_pkg::CAPACITY:0]      above;

  assign accept = start && (state_r == S_IDLE);
  assign full   = (count_r >= ast_pkg::CNT_W'(ast_pkg::CAPACITY));

  // Control broadcast to the cells
  always_comb begin
    bus.cmp       = (state_r == S_CMP);
    bus.exec      = (state_r == S_EXEC);
    bus.req       = req_r;
    bus.value     = value_r;
    bus.count     = count_r;
    bus.full      = full;
    bus.any_match = above[0];
  end

  // Cell chain; the top cell has no upper neighbor
  assign above[ast_pkg::CAPACITY] = 1'b0;

  for (genvar i = 0; i < ast_pkg::CAPACITY; i++) begin : g_cell
    logic [ast_pkg::ELEM_W-1:0] nb_entry;
    if (i == ast_pkg::CAPACITY - 1) begin : g_top
      assign nb_entry = entry_q[i];
    end else begin : g_mid
      assign nb_entry = entry_q[i+1];
    end
    ast_cell u_cell (
      .clk        (clk),
      .idx        (ast_pkg::CNT_W'(i)),
      .bus        (bus),
      .next_entry (nb_entry),
      .above_in   (above[i+1]),
      .entry      (entry_q[i]),
      .above_out  (above[i])
    );
  end

  // Result and count for the transaction in the update phase
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ast_pkg::ST_OK;
    found_nxt  = 1'b0;
    case (req_r)
      ast_pkg::REQ_ADD: begin
        if (full) begin
          status_nxt = ast_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      ast_pkg::REQ_REMOVE: begin
        if (above[0]) begin
          count_nxt = count_r - 1'b1;
        end else begin
          status_nxt = ast_pkg::ST_ABSENT;
        end
      end
      ast_pkg::REQ_QUERY: begin
        found_nxt = above[0];
      end
      default: begin
        status_nxt = ast_pkg::ST_OK;
      end
    endcase
  end

  // Sequencer, count and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r     <= S_IDLE;
          count_r     <= count_nxt;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      value_r <= in_elem_value[ast_pkg::ELEM_W-1:0];
    end
    if (state_r == S_EXEC) begin
      out_status_r <= status_nxt;
      out_found_r  <= found_nxt;
      out_count_r  <= ast_pkg::OUT_CNT_W'(count_nxt);
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_entry_count = out_count_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ast_pkg::CNT_W'(ast_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> out_valid)
    else $error("update phase without result strobe");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid)
    else $error("accepted transaction did not raise busy");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ast_pkg::ST_FULL)) |->
      (count_r == ast_pkg::CNT_W'(ast_pkg::CAPACITY)))
    else $error("full status reported below capacity");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == ast_pkg::ST_OK) && (req_r == ast_pkg::REQ_QUERY))
    else $error("found flag on a non-query result");

endmodule

// ===== hw/rtl/ast_cell.sv =====
// One storage cell of the set chain: holds an entry, compares it and shifts from its upper neighbor.
module ast_cell (
  input  logic                            clk,
  input  logic [ast_pkg::CNT_W-1:0]       idx,
  input  ast_pkg::cell_bus_t              bus,
  input  logic [ast_pkg::ELEM_W-1:0]      next_entry,
  input  logic                            above_in,
  output logic [ast_pkg::ELEM_W-1:0]      entry,
  output logic                            above_out
);

  logic [ast_pkg::ELEM_W-1:0] entry_r;
  logic [ast_pkg::ELEM_W-1:0] entry_nxt;
  logic                       match_r;
  logic                       match_nxt;
  logic                       in_use;

  assign in_use = (idx < bus.count);

  // Match flag: valid entry equal to the request value
  always_comb begin
    match_nxt = match_r;
    if (bus.cmp) begin
      match_nxt = in_use && (entry_r == bus.value);
    end
  end

  // Entry update: append at the tail, or shift down at and above the last match
  always_comb begin
    entry_nxt = entry_r;
    if (bus.exec) begin
      if ((bus.req == ast_pkg::REQ_ADD) && !bus.full && (idx == bus.count)) begin
        entry_nxt = bus.value;
      end else if ((bus.req == ast_pkg::REQ_REMOVE) && bus.any_match && !above_in) begin
        entry_nxt = next_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  // Ripple toward cell zero: a match exists at this cell or above
  assign above_out = above_in | match_r;
  assign entry     = entry_r;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for array_set_table_top: directed table, then random request phases.
module testbench;

  localparam logic [ast_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int N_DIR       = 23;
  localparam int N_RANDOM    = 1000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 6;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_QUERY} phase_mode_t;

  typedef struct packed {
    logic [ast_pkg::STATUS_W-1:0]  status;
    logic                          found;
    logic [ast_pkg::OUT_CNT_W-1:0] cnt;
  } set_result_t;

  typedef struct packed {
    logic [ast_pkg::REQ_W-1:0] req;
    logic [ast_pkg::VAL_W-1:0] value;
    logic                      typed;   // expected result given in the row
    set_result_t               res;
  } dir_row_t;

  // Directed rows: empty store, extremes, duplicates, unused code, shifting removes
  dir_row_t dir_rows [0:N_DIR-1] = '{
    '{ast_pkg::REQ_QUERY,  16'h0000, 1'b1, '{ast_pkg::ST_OK,     1'b0, 7'd0}},
    '{ast_pkg::REQ_REMOVE, 16'hFFFF, 1'b1, '{ast_pkg::ST_ABSENT, 1'b0, 7'd0}},
    '{ast_pkg::REQ_ADD,    16'h0000, 1'b1, '{ast_pkg::ST_OK,     1'b0, 7'd1}},
    '{ast_pkg::REQ_ADD,    16'hFFFF, 1'b1, '{ast_pkg::ST_OK,     1'b0, 7'd2}},
    '{ast_pkg::REQ_QUERY,  16'hFFFF, 1'b1, '{ast_pkg::ST_OK,     1'b1, 7'd2}},
    '{ast_pkg::REQ_QUERY,  16'h0000, 1'b1, '{ast_pkg::ST_OK,     1'b1, 7'd2}},
    '{ast_pkg::REQ_QUERY,  16'h5555, 1'b1, '{ast_pkg::ST_OK,     1'b0, 7'd2}},
    '{ast_pkg::REQ_ADD,    16'h1234, 1'b0, '{ast_pkg::ST_OK,     1'b0, 7'd0}},
    '{ast_pkg::REQ_ADD,    16'hAAAA, 1'b0, '{ast_pkg::ST_OK,     1'b0, 7'd0}},
    '{ast_pkg::REQ_ADD,    16'h1234, 1'b0, '{ast_pkg::ST_OK,     1'b0, 7'd0}},
    '{ast_pkg::REQ_ADD,    16'h5555, 1'b0, '{ast_pkg::ST_OK,     1'b0, 7'd0}},
    '{REQ_UNUSED,          16'h1234, 1'b1, '{ast_pkg::ST_OK,     1'b0, 7'd6}},
    '{ast_pkg::REQ_REMOVE, 16'h1234, 1'b1, '{ast_pkg::ST_OK,     1'b0, 7'd5}},
    '{ast_pkg::REQ_QUERY,  16'h1234, 1'b1, '{ast_pkg::ST_OK,     1'b1, 7'd5}},
    '{ast_pkg::REQ_REMOVE, 16'h1234, 1'b1, '{ast_pkg::ST_OK,     1'b0, 7'd4}},
    '{ast_pkg::REQ_QUERY,  16'h1234, 1'b1, '{ast_pkg::ST_OK,     1'b0, 7'd4}},
    '{ast_pkg::REQ_REMOVE, 16'h1234, 1'b1, '{ast_pkg::ST_ABSENT, 1'b0, 7'd4}},
    '{ast_pkg::REQ_REMOVE, 16'h0000, 1'b1, '{ast_pkg::ST_OK,     1'b0, 7'd3}},
    '{ast_pkg::REQ_QUERY,  16'hAAAA, 1'b0, '{ast_pkg::ST_OK,     1'b0, 7'd0}},
    '{ast_pkg::REQ_REMOVE, 16'h5555, 1'b0, '{ast_pkg::ST_OK,     1'b0, 7'd0}},
    '{ast_pkg::REQ_ADD,    16'h8001, 1'b0, '{ast_pkg::ST_OK,     1'b0, 7'd0}},
    '{ast_pkg::REQ_QUERY,  16'hFFFE, 1'b0, '{ast_pkg::ST_OK,     1'b0, 7'd0}},
    '{ast_pkg::REQ_REMOVE, 16'hFFFF, 1'b0, '{ast_pkg::ST_OK,     1'b0, 7'd0}}
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [ast_pkg::REQ_W-1:0]     in_req_type = '0;
  logic [ast_pkg::VAL_W-1:0]     in_elem_value = '0;
  logic                          out_valid;
  logic [ast_pkg::STATUS_W-1:0]  out_status;
  logic                          out_found;
  logic [ast_pkg::OUT_CNT_W-1:0] out_entry_count;

  // Predictor state and expected results
  logic [ast_pkg::ELEM_W-1:0] held_values [$];
  set_result_t                pending_results [$];
  int                         mismatches = 0;
  int                         cycles = 0;
  bit                         no_idle = 1'b0;
  logic [ast_pkg::VAL_W-1:0]  value_pool [POOL_SIZE];

  array_set_table_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_elem_value   (in_elem_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_entry_count (out_entry_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Apply one request to the predicted store, return the expected result
  function automatic set_result_t apply_request(logic [ast_pkg::REQ_W-1:0] req,
                                                logic [ast_pkg::VAL_W-1:0] value);
    set_result_t res;
    int pos;
    res.status = ast_pkg::ST_OK;
    res.found  = 1'b0;
    pos = -1;
    for (int i = 0; i < held_values.size(); i++) begin
      if (held_values[i] == value[ast_pkg::ELEM_W-1:0]) pos = i;
    end
    case (req)
      ast_pkg::REQ_ADD: begin
        if (held_values.size() >= ast_pkg::CAPACITY) res.status = ast_pkg::ST_FULL;
        else held_values.push_back(value[ast_pkg::ELEM_W-1:0]);
      end
      ast_pkg::REQ_REMOVE: begin
        if (pos < 0) res.status = ast_pkg::ST_ABSENT;
        else held_values.delete(pos);
      end
      ast_pkg::REQ_QUERY: res.found = (pos >= 0);
      default: ;
    endcase
    res.cnt = ast_pkg::OUT_CNT_W'(held_values.size());
    return res;
  endfunction

  // Present one transaction, wait for acceptance, record its expectation
  task automatic send_request(logic [ast_pkg::REQ_W-1:0] req, logic [ast_pkg::VAL_W-1:0] value,
                              bit typed, set_result_t typed_res);
    set_result_t res;
    start         <= 1'b1;
    in_req_type   <= req;
    in_elem_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    res = apply_request(req, value);
    pending_results.push_back(typed ? typed_res : res);
    if (!no_idle && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected result is back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ast_pkg::VAL_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 25) return ast_pkg::VAL_W'($urandom_range(0, 65535));
    return value_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Result checker
  always @(posedge clk) begin
    set_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result: status %0d found %0d count %0d",
                   out_status, out_found, out_entry_count);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status || out_found !== exp_res.found ||
            out_entry_count !== exp_res.cnt) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected status %0d found %0d count %0d, got %0d %0d %0d",
                     exp_res.status, exp_res.found, exp_res.cnt,
                     out_status, out_found, out_entry_count);
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int sent;
    int phase_len;
    int roll;
    phase_mode_t mode;
    logic [ast_pkg::REQ_W-1:0] req;
    logic [ast_pkg::VAL_W-1:0] value;
    set_result_t unused_res;

    unused_res = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].res);
    wait_drained();

    // Random phases; the first one fills the store past capacity
    sent = 0;
    mode = MODE_FILL;
    while (sent < N_RANDOM) begin
      foreach (value_pool[k]) value_pool[k] = ast_pkg::VAL_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) == 0) value_pool[0] = '1;
      if ($urandom_range(0, 3) == 0) value_pool[1] = '0;
      phase_len = (sent == 0) ? 120 : $urandom_range(40, 140);
      for (int n = 0; n < phase_len && sent < N_RANDOM; n++) begin
        no_idle = (sent >= 400 && sent < 600);
        roll = $urandom_range(0, 99);
        if (roll < 3) req = REQ_UNUSED;
        else begin
          case (mode)
            MODE_FILL:  req = (roll < 85) ? ast_pkg::REQ_ADD :
                              ((roll < 93) ? ast_pkg::REQ_REMOVE : ast_pkg::REQ_QUERY);
            MODE_DRAIN: req = (roll < 80) ? ast_pkg::REQ_REMOVE :
                              ((roll < 90) ? ast_pkg::REQ_ADD : ast_pkg::REQ_QUERY);
            MODE_MIX:   req = (roll < 40) ? ast_pkg::REQ_ADD :
                              ((roll < 70) ? ast_pkg::REQ_REMOVE : ast_pkg::REQ_QUERY);
            default:    req = (roll < 25) ? ast_pkg::REQ_ADD :
                              ((roll < 40) ? ast_pkg::REQ_REMOVE : ast_pkg::REQ_QUERY);
          endcase
        end
        // Removes and queries mostly target values that are held
        if (req != ast_pkg::REQ_ADD && held_values.size() > 0 && $urandom_range(0, 99) < 60)
          value = held_values[$urandom_range(0, held_values.size() - 1)];
        else
          value = pick_value();
        send_request(req, value, 1'b0, unused_res);
        sent++;
      end
      if (sent >= 500 && sent < 500 + 140) wait_drained();
      mode = phase_mode_t'($urandom_range(0, 3));
    end

    // Wind down
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
